/* rtl/core/aesk_pkg.sv */
`default_nettype none

package aesk_pkg;

  localparam int unsigned NumRoundKeys = 11;
  localparam logic [3:0] LastIndex = 4'(NumRoundKeys - 1);
  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] RconPoly = 8'h1B;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } key_t;

  typedef struct packed {
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
    logic [3:0]  round_index;
    logic        last_round;
  } round_key_t;

  typedef logic [3:0][31:0] words_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

`default_nettype wire

/* rtl/core/aesk_round.sv */
`default_nettype none

module aesk_round import aesk_pkg::*; (
  input  var words_t     words,
  input  var logic [7:0] rcon,
  output var words_t     words_next,
  output var logic [7:0] rcon_next
);

  logic [31:0] rot;
  logic [31:0] sub;
  logic [31:0] temp;

  // words[3] is word 0 (most significant), words[0] is word 3
  assign rot = {words[0][23:0], words[0][31:24]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sub[8*i +: 8] = SBOX[rot[8*i +: 8]];
    end
  end

  assign temp = sub ^ {rcon, 24'h000000};

  assign words_next[3] = words[3] ^ temp;
  assign words_next[2] = words[2] ^ words_next[3];
  assign words_next[1] = words[1] ^ words_next[2];
  assign words_next[0] = words[0] ^ words_next[1];

  // doubling in gf(2^8)
  assign rcon_next = {rcon[6:0], 1'b0} ^ (rcon[7] ? RconPoly : 8'h00);

endmodule

`default_nettype wire

/* rtl/core/aes128_key_expansion_core.sv */
// Round key 0 is shown in the cycle after a request is accepted, and round keys 1 to 10
// follow it, one round key per cycle from the shared round unit.
// A request is accepted only while busy is low; busy stays high until round key 10 is shown.
// Results are strobed on valid for one cycle each; the receiver cannot stall.
// Reset (rst, synchronous, active high) clears busy, valid and the round state.
`default_nettype none

module aes128_key_expansion_core import aesk_pkg::*; (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       start,
  output var logic       busy,
  input  var key_t       key,
  output var logic       valid,
  output var round_key_t round_key
);

  words_t     words;
  logic [3:0] count;
  logic [7:0] rcon;
  words_t     words_next;
  logic [7:0] rcon_next;
  logic [3:0] count_next;
  logic       accept;

  assign accept     = start & ~busy;
  assign count_next = count + 4'd1;

  aesk_round u_round (
    .words      (words),
    .rcon       (rcon),
    .words_next (words_next),
    .rcon_next  (rcon_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      count <= '0;
      rcon  <= RconInit;
      words <= '0;
    end else begin
      valid <= 1'b0;
      if (accept) begin
        busy  <= 1'b1;
        valid <= 1'b1;
        count <= '0;
        rcon  <= RconInit;
        words <= {key.key_high, key.key_low};
      end else if (busy) begin
        valid <= 1'b1;
        count <= count_next;
        rcon  <= rcon_next;
        words <= words_next;
        if (count_next == LastIndex) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      round_key.round_key_high <= key.key_high;
      round_key.round_key_low  <= key.key_low;
      round_key.round_index    <= '0;
      round_key.last_round     <= 1'b0;
    end else if (busy) begin
      round_key.round_key_high <= {words_next[3], words_next[2]};
      round_key.round_key_low  <= {words_next[1], words_next[0]};
      round_key.round_index    <= count_next;
      round_key.last_round     <= (count_next == LastIndex);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/aesk_checker.sv */
`default_nettype none

module aesk_checker import aesk_pkg::*; (
  input var logic       clk,
  input var logic       rst,
  input var logic       start,
  input var logic       busy,
  input var key_t       key,
  input var logic       valid,
  input var round_key_t round_key
);

  // a new request opens with round key 0
  a_first: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> valid && round_key.round_index == '0)
    else $error("request did not open with round key 0");

  // round keys follow back to back until the last
  a_run: assert property (@(posedge clk) disable iff (rst)
    valid && !round_key.last_round |=> valid &&
      round_key.round_index == $past(round_key.round_index) + 4'd1)
    else $error("round key sequence broken");

  a_last: assert property (@(posedge clk) disable iff (rst)
    valid |-> round_key.last_round == (round_key.round_index == LastIndex))
    else $error("last_round flag mismatch");

  a_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> valid && round_key.last_round)
    else $error("busy dropped before the last round key");

  a_key: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> round_key.round_key_high == $past(key.key_high) &&
      round_key.round_key_low == $past(key.key_low))
    else $error("round key 0 differs from the key");

endmodule

bind aes128_key_expansion_core aesk_checker u_aesk_checker (.*);

`default_nettype wire
